[sv/fbosc_pkg.sv]
// Package for the feedback sine oscillator: fixed-point constants, reset values
// and the divisor sequence of the sine polynomial. No dependencies.
package fbosc_pkg;

    localparam int          SINE_DEPTH_DEF  = 1024;
    localparam logic [30:0] ISR_RESET       = 31'd22906492;
    localparam logic [32:0] Q30_ONE         = 33'd1073741824;
    localparam logic [32:0] HALF_PI_Q30     = 33'd1686629713;
    localparam logic [32:0] OUT_SCALE       = 33'd32767;
    localparam logic [14:0] MAG_MAX         = 15'd32767;

    // Horner divisors of the odd Taylor series, highest order first.
    function automatic logic [6:0] fbosc_div(input logic [2:0] k);
        logic [6:0] d;
        case (k)
            3'd0:    d = 7'd110;
            3'd1:    d = 7'd72;
            3'd2:    d = 7'd42;
            3'd3:    d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

endpackage

[sv/feedback_sine_oscillator.sv]
// Feedback FM sine oscillator, one sample out per input beat.
// Twelve products run on one shared bit-serial multiplier, each followed by a
// step state, and five quotients on a bit-serial divider, each followed by a
// step state; S_OUT then loads the output register, waiting while the output
// stalls. A new beat is accepted only in S_IDLE, once the last sample is done.
// Reset (synchronous, active low) clears phase, history and handshakes and loads
// the register defaults.
module feedback_sine_oscillator
    import fbosc_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [23:0] i_freq_hz,
    input  logic signed [15:0] i_feedback_amount,
    input  logic        [15:0] i_phase_offset,
    input  logic signed [17:0] i_sync_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_sample_out,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic        [2:0]  i_paddr,
    input  logic        [31:0] i_pwdata,
    output logic        [31:0] o_prdata,
    output logic               o_pready
);

    // The table depth is to be a power of two (the block does not check it); the index is the top bits of the phase.
    localparam int L = $clog2(SINE_TABLE_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_NEXT = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DIVN = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [3:0] OP_FF  = 4'd0;  // |fb| * |F|
    localparam logic [3:0] OP_T   = 4'd1;  // ... * |prev_out_1|
    localparam logic [3:0] OP_X   = 4'd2;  // folded angle * pi/2
    localparam logic [3:0] OP_X2  = 4'd3;  // x * x
    localparam logic [3:0] OP_XT  = 4'd4;  // x2 * t, Horner step
    localparam logic [3:0] OP_S   = 4'd5;  // x * t
    localparam logic [3:0] OP_MAG = 4'd6;  // s * 32767
    localparam logic [3:0] OP_INC = 4'd7;  // |freq| * inv_sample_rate

    logic [2:0]  r_state;
    logic [3:0]  r_op;
    logic        r_filt;
    logic [30:0] r_isr;
    logic [31:0] r_phase;
    logic signed [15:0] r_p1, r_p2;
    logic [15:0] r_poff;
    logic signed [23:0] r_freq;
    logic        r_tsgn;
    logic [1:0]  r_quad;
    logic [32:0] r_x, r_x2;
    logic [2:0]  r_k;
    logic signed [15:0] r_y;
    logic        r_ovalid;
    logic signed [15:0] r_out;

    // Shared bit-serial multiplier: the high half takes the multiplicand when
    // the low bit of the multiplier is set, then the product shifts right.
    logic [32:0] r_ma, r_mb;
    logic [65:0] r_mp;
    logic [5:0]  r_cnt;

    // Bit-serial restoring divider by a small constant.
    logic [31:0] r_dq;
    logic [6:0]  r_dr;

    // APB register access. Writes are expected only while the block is idle.
    assign o_pready = 1'b1;
    always_comb begin
        if (i_paddr[2]) begin
            o_prdata = {1'b0, r_isr};
        end else begin
            o_prdata = {31'd0, r_filt};
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_sample_out = r_out;

    // Phase after the offset change and sync, worked out at acceptance.
    logic [15:0] w_doff;
    logic [31:0] w_phase0;
    logic signed [16:0] w_sum;
    logic signed [15:0] w_fmul;
    logic [16:0] w_fb_mag, w_fm_mag, w_p1_mag;
    always_comb begin
        w_doff   = i_phase_offset - r_poff;
        w_phase0 = r_phase + {w_doff, 16'd0};
        if (i_sync_value > 18'sd0 && i_sync_value <= 18'sd65536) begin
            w_phase0 = {i_sync_value[15:0], 16'd0};
        end
        w_sum = 17'(r_p1) + 17'(r_p2);
        w_fmul = r_filt ? w_sum[16:1] : r_p1;
        w_fb_mag = i_feedback_amount[15] ? 17'(-17'(i_feedback_amount))
                                         : 17'(i_feedback_amount);
        w_fm_mag = w_fmul[15] ? 17'(-17'(w_fmul)) : 17'(w_fmul);
        w_p1_mag = r_p1[15] ? 17'(-17'(r_p1)) : 17'(r_p1);
    end

    // Results drawn from a finished product, and the divider's step terms.
    logic [33:0] w_msum;
    logic [63:0] w_term;
    logic [31:0] w_theta;
    logic [31:0] w_f;
    logic [30:0] w_rr;
    logic [32:0] w_hi30;
    logic [65:0] w_round;
    logic [35:0] w_mag;
    logic [14:0] w_mag_sat;
    logic [63:0] w_inc;
    logic [7:0]  w_rem;
    logic [7:0]  w_rem_sub;
    logic [6:0]  w_dv;
    logic [32:0] w_t;
    logic [23:0] w_freq_mag;
    always_comb begin
        w_msum  = {1'b0, r_mp[65:33]} + (r_mb[0] ? {1'b0, r_ma} : 34'd0);
        w_term  = r_tsgn ? -r_mp[63:0] : r_mp[63:0];
        w_term  = w_term + 64'd512;
        w_theta = r_phase + w_term[41:10];
        w_f     = {w_theta[31 -: L], {(32 - L){1'b0}}};
        w_rr    = w_f[30] ? 31'(Q30_ONE[30:0] - {1'b0, w_f[29:0]}) : {1'b0, w_f[29:0]};
        w_hi30  = r_mp[62:30];
        w_round = r_mp + 66'(1 << 29);
        w_mag   = w_round[65:30];
        w_mag_sat = (w_mag > 36'(MAG_MAX)) ? MAG_MAX : w_mag[14:0];
        w_inc   = r_freq[23] ? -r_mp[63:0] : r_mp[63:0];
        w_inc   = w_inc + 64'd32768;
        w_dv    = fbosc_div(r_k);
        w_rem   = {r_dr, r_dq[31]};
        w_rem_sub = w_rem - {1'b0, w_dv};
        w_t     = Q30_ONE - {1'b0, r_dq};
        w_freq_mag = r_freq[23] ? 24'(-r_freq) : 24'(r_freq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_FF;
            r_filt   <= 1'b0;
            r_isr    <= ISR_RESET;
            r_phase  <= 32'd0;
            r_p1     <= 16'sd0;
            r_p2     <= 16'sd0;
            r_poff   <= 16'd0;
            r_ovalid <= 1'b0;
            r_cnt    <= 6'd0;
        end else begin
            if (i_psel && i_penable && i_pwrite) begin
                if (i_paddr[2]) begin
                    r_isr <= i_pwdata[30:0];
                end else begin
                    r_filt <= i_pwdata[0];
                end
            end

            // The output register fills from S_OUT once it is free or being taken.
            if (r_state == S_OUT && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_phase <= w_phase0;
                        r_poff  <= i_phase_offset;
                        r_freq  <= i_freq_hz;
                        r_tsgn  <= i_feedback_amount[15] ^ w_fmul[15] ^ r_p1[15];
                        r_ma    <= {16'd0, w_fb_mag};
                        r_mb    <= {16'd0, w_fm_mag};
                        r_mp    <= 66'd0;
                        r_cnt   <= 6'd0;
                        r_op    <= OP_FF;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_mp  <= {w_msum, r_mp[32:1]};
                    r_mb  <= {1'b0, r_mb[32:1]};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd32) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    // Default: start another product from a cleared accumulator.
                    r_mp    <= 66'd0;
                    r_cnt   <= 6'd0;
                    r_state <= S_MUL;
                    case (r_op)
                        OP_FF: begin
                            r_ma <= r_mp[32:0];
                            r_mb <= {16'd0, w_p1_mag};
                            r_op <= OP_T;
                        end
                        OP_T: begin
                            r_quad <= w_f[31:30];
                            r_ma   <= {2'd0, w_rr};
                            r_mb   <= HALF_PI_Q30;
                            r_op   <= OP_X;
                        end
                        OP_X: begin
                            r_x  <= w_hi30;
                            r_ma <= w_hi30;
                            r_mb <= w_hi30;
                            r_op <= OP_X2;
                        end
                        OP_X2: begin
                            r_x2 <= w_hi30;
                            r_k  <= 3'd0;
                            r_ma <= w_hi30;
                            r_mb <= Q30_ONE;
                            r_op <= OP_XT;
                        end
                        OP_XT: begin
                            r_dq    <= w_hi30[31:0];
                            r_dr    <= 7'd0;
                            r_state <= S_DIV;
                        end
                        OP_S: begin
                            r_ma <= w_hi30;
                            r_mb <= OUT_SCALE;
                            r_op <= OP_MAG;
                        end
                        OP_MAG: begin
                            r_y  <= r_quad[1] ? -$signed({1'b0, w_mag_sat})
                                              : $signed({1'b0, w_mag_sat});
                            r_ma <= {9'd0, w_freq_mag};
                            r_mb <= {2'd0, r_isr};
                            r_op <= OP_INC;
                        end
                        default: begin
                            // Phase increment lands, the history shifts.
                            r_phase <= r_phase + w_inc[47:16];
                            r_p2    <= r_p1;
                            r_p1    <= r_y;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_DIV: begin
                    if (w_rem >= {1'b0, w_dv}) begin
                        r_dr <= w_rem_sub[6:0];
                        r_dq <= {r_dq[30:0], 1'b1};
                    end else begin
                        r_dr <= w_rem[6:0];
                        r_dq <= {r_dq[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_state <= S_DIVN;
                    end
                end
                S_DIVN: begin
                    // One Horner step done: t = 1 - x2*t/d.
                    r_mp    <= 66'd0;
                    r_cnt   <= 6'd0;
                    r_mb    <= w_t;
                    r_k     <= r_k + 3'd1;
                    r_state <= S_MUL;
                    if (r_k == 3'd4) begin
                        r_ma <= r_x;
                        r_op <= OP_S;
                    end else begin
                        r_ma <= r_x2;
                        r_op <= OP_XT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_out    <= r_p1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
